### hdl/assert_macros.svh
// Assertion macros used by the checker of the alert classifier.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with an active-low reset that disables it.
`define ACWH_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Overlapping implication built on the macro above.
`define ACWH_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  `ACWH_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

// Next-cycle implication built on the first macro.
`define ACWH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  `ACWH_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

### hdl/acwh_pkg.sv
// Package of the alert classifier: level and register codes, frame and result
// records, thresholds and haptic tables. No dependencies.
package acwh_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  typedef enum logic [2:0] {
    LVL_NOMINAL  = 3'd0,
    LVL_ADVISORY = 3'd1,
    LVL_CAUTION  = 3'd2,
    LVL_PULLOVER = 3'd3,
    LVL_ESCALATE = 3'd4
  } level_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HYST_UP    = 3'd0,
    CFG_HYST_DOWN  = 3'd1,
    CFG_DRIVE_LIM  = 3'd2,
    CFG_CRASH_G    = 3'd3,
    CFG_HEART_HIGH = 3'd4,
    CFG_HEART_LOW  = 3'd5
  } cfg_idx_e;

  localparam logic [3:0] COUNT_MAX = 4'd15;

  localparam logic [3:0]  RST_HYST_UP    = 4'd3;
  localparam logic [3:0]  RST_HYST_DOWN  = 4'd8;
  localparam logic [23:0] RST_DRIVE_LIM  = 24'd5400;
  localparam logic [11:0] RST_CRASH_G    = 12'd512;
  localparam logic [7:0]  RST_HEART_HIGH = 8'd120;
  localparam logic [7:0]  RST_HEART_LOW  = 8'd45;

  localparam logic [9:0]  SPO2_CRIT  = 10'd920;
  localparam logic [15:0] HRV_CRIT   = 16'd150;
  localparam logic [15:0] HRV_LOW    = 16'd200;
  localparam logic [13:0] EAR_CRIT   = 14'd1500;
  localparam logic [13:0] PCL_CRIT   = 14'd8000;
  localparam logic [13:0] PCL_YAWN   = 14'd2500;
  localparam logic [13:0] PCL_ADV    = 14'd1500;
  localparam logic [7:0]  YAWN_MIN   = 8'd3;

  typedef struct packed {
    logic [11:0] g_peak;
    logic [9:0]  oxygen_sat;
    logic [15:0] hrv;
    logic [13:0] eye_aspect;
    logic [13:0] eye_closure;
    logic [7:0]  heart_rate;
    logic [7:0]  yawns;
    logic        ecg_lost;
    logic [23:0] drive_time;
  } frame_t;

  typedef struct packed {
    logic [2:0]  raw_level;
    logic [2:0]  stable_level;
    logic [6:0]  haptic_percent;
    logic [11:0] haptic_ms;
    logic [6:0]  haptic_hz;
  } result_t;

  typedef struct packed {
    logic [3:0]  hyst_up;
    logic [3:0]  hyst_down;
    logic [23:0] drive_limit_s;
    logic [11:0] crash_g;
    logic [7:0]  heart_high;
    logic [7:0]  heart_low;
  } cfg_t;

  function automatic logic [6:0] haptic_pct(level_e lvl);
    logic [6:0] r;
    unique case (lvl)
      LVL_ADVISORY: r = 7'd30;
      LVL_CAUTION:  r = 7'd60;
      LVL_PULLOVER: r = 7'd85;
      LVL_ESCALATE: r = 7'd100;
      default:      r = 7'd0;
    endcase
    return r;
  endfunction

  function automatic logic [11:0] haptic_dur(level_e lvl);
    logic [11:0] r;
    unique case (lvl)
      LVL_ADVISORY: r = 12'd500;
      LVL_CAUTION:  r = 12'd800;
      LVL_PULLOVER: r = 12'd2000;
      LVL_ESCALATE: r = 12'd3000;
      default:      r = 12'd0;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] haptic_rate(level_e lvl);
    logic [6:0] r;
    unique case (lvl)
      LVL_ADVISORY: r = 7'd40;
      LVL_CAUTION:  r = 7'd60;
      LVL_PULLOVER: r = 7'd80;
      LVL_ESCALATE: r = 7'd100;
      default:      r = 7'd0;
    endcase
    return r;
  endfunction

endpackage

### hdl/acwh_ifs.sv
// Request channels of the alert classifier: sensor frames in, results out.
// Depends on acwh_pkg.
interface acwh_in_if;
  import acwh_pkg::*;
  logic   valid;
  logic   ready;
  frame_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface acwh_out_if;
  import acwh_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/acwh_classify.sv
// Prioritised threshold classifier: one frame to a raw alert level.
// Depends on acwh_pkg.
module acwh_classify (
  input  acwh_pkg::frame_t frame_i,
  input  acwh_pkg::cfg_t   cfg_i,
  output acwh_pkg::level_e raw_o
);
  import acwh_pkg::*;

  always_comb begin
    priority if (frame_i.g_peak >= cfg_i.crash_g) begin
      raw_o = LVL_ESCALATE;
    end else if (frame_i.oxygen_sat < SPO2_CRIT && frame_i.hrv < HRV_CRIT) begin
      raw_o = LVL_ESCALATE;
    end else if (frame_i.eye_aspect < EAR_CRIT || frame_i.eye_closure > PCL_CRIT) begin
      raw_o = LVL_ESCALATE;
    end else if (frame_i.heart_rate > cfg_i.heart_high ||
                 (frame_i.heart_rate != 8'd0 && frame_i.heart_rate < cfg_i.heart_low)) begin
      raw_o = LVL_PULLOVER;
    end else if (frame_i.eye_closure > PCL_YAWN && frame_i.yawns >= YAWN_MIN) begin
      raw_o = LVL_CAUTION;
    end else if (frame_i.hrv < HRV_LOW && !frame_i.ecg_lost) begin
      raw_o = LVL_ADVISORY;
    end else if (frame_i.drive_time > cfg_i.drive_limit_s) begin
      raw_o = LVL_ADVISORY;
    end else if (frame_i.eye_closure > PCL_ADV) begin
      raw_o = LVL_ADVISORY;
    end else begin
      raw_o = LVL_NOMINAL;
    end
  end

endmodule

### hdl/alert_classify_with_hysteresis_unit.sv
// Top level of the alert classifier with hysteresis.
// Depends on acwh_pkg, acwh_ifs and acwh_classify.
//
// Usage:
//   in_if   : sensor frame requests (valid/ready), one frame per request.
//   out_if  : one result request per frame: raw level, stable level and the
//             haptic intensity, duration and PWM rate of the stable level.
//   cfg_*   : register writes, index 0..5, taken at any edge with cfg_we_i high;
//             other indexes are ignored. Write only while the block is idle.
// Timing:
//   A taken frame is held in the input register and its result in the result
//   register; classification and the hysteresis update sit between the
//   input and result registers. One frame per cycle is sustained while each
//   result is taken; the hysteresis state loop closes through combinational logic.
// Reset:
//   Configuration registers return to their defaults, levels to nominal, both stages empty.
// Stall:
//   A result that is not taken is held; the input register still accepts one
//   more frame, after which in_if.ready stays low until the result is taken.
module alert_classify_with_hysteresis_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  acwh_in_if.sink                        in_if,
  acwh_out_if.source                     out_if,
  input  logic                           cfg_we_i,
  input  logic [acwh_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [acwh_pkg::CfgDataW-1:0]  cfg_data_i
);
  import acwh_pkg::*;

  cfg_t    cfg_q;
  frame_t  s1_data_q;
  logic    s1_valid_q, s1_valid_d;
  logic    out_valid_q, out_valid_d;
  result_t res_q, res_d;
  level_e  cur_q, cur_d, pend_q, pend_d;
  logic [3:0] cnt_q, cnt_d, cnt_inc, thr;
  level_e  raw;
  logic    s2_free, s2_load, in_take, adopt;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hyst_up       <= RST_HYST_UP;
      cfg_q.hyst_down     <= RST_HYST_DOWN;
      cfg_q.drive_limit_s <= RST_DRIVE_LIM;
      cfg_q.crash_g       <= RST_CRASH_G;
      cfg_q.heart_high    <= RST_HEART_HIGH;
      cfg_q.heart_low     <= RST_HEART_LOW;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_HYST_UP:    cfg_q.hyst_up       <= cfg_data_i[3:0];
        CFG_HYST_DOWN:  cfg_q.hyst_down     <= cfg_data_i[3:0];
        CFG_DRIVE_LIM:  cfg_q.drive_limit_s <= cfg_data_i[23:0];
        CFG_CRASH_G:    cfg_q.crash_g       <= cfg_data_i[11:0];
        CFG_HEART_HIGH: cfg_q.heart_high    <= cfg_data_i[7:0];
        CFG_HEART_LOW:  cfg_q.heart_low     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign s2_free      = !out_valid_q || out_if.ready;
  assign s2_load      = s1_valid_q && s2_free;
  assign in_if.ready  = !s1_valid_q || s2_free;
  assign in_take      = in_if.valid && in_if.ready;
  assign s1_valid_d   = in_take ? 1'b1 : (s2_free ? 1'b0 : s1_valid_q);
  assign out_valid_d  = s2_free ? s1_valid_q : 1'b1;

  acwh_classify u_classify (
    .frame_i (s1_data_q),
    .cfg_i   (cfg_q),
    .raw_o   (raw)
  );

  // hysteresis
  always_comb begin
    if (raw == pend_q) begin
      cnt_inc = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 4'd1;
    end else begin
      cnt_inc = 4'd1;
    end
    thr    = (raw > cur_q) ? cfg_q.hyst_up : cfg_q.hyst_down;
    adopt  = cnt_inc >= thr;
    pend_d = raw;
    cur_d  = adopt ? raw : cur_q;
    cnt_d  = adopt ? 4'd0 : cnt_inc;

    res_d.raw_level      = raw;
    res_d.stable_level   = cur_d;
    res_d.haptic_percent = haptic_pct(cur_d);
    res_d.haptic_ms      = haptic_dur(cur_d);
    res_d.haptic_hz      = haptic_rate(cur_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cur_q       <= LVL_NOMINAL;
      pend_q      <= LVL_NOMINAL;
      cnt_q       <= 4'd0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s2_load) begin
        cur_q  <= cur_d;
        pend_q <= pend_d;
        cnt_q  <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_data_q <= in_if.data;
    end
    if (s2_load) begin
      res_q <= res_d;
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data  = res_q;

endmodule

### hdl/acwh_checker.sv
// Port-level checks of the alert classifier, bound to the top level.
// Depends on acwh_pkg and assert_macros.svh.
`include "assert_macros.svh"

module acwh_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input acwh_pkg::result_t out_data_i
);
  import acwh_pkg::*;

  `ACWH_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result request dropped while stalled")
  `ACWH_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_data_i), "stalled result changed")
  `ACWH_ASSERT_IMP(a_level_range, clk_i, rst_ni, out_valid_i, out_data_i.raw_level <= LVL_ESCALATE && out_data_i.stable_level <= LVL_ESCALATE, "level out of range")
  `ACWH_ASSERT_IMP(a_haptic_match, clk_i, rst_ni, out_valid_i, (out_data_i.stable_level == LVL_NOMINAL) == (out_data_i.haptic_percent == 7'd0), "haptic does not follow stable level")
  `ACWH_ASSERT_IMP(a_ready_empty, clk_i, rst_ni, !out_valid_i, in_ready_i, "input blocked with empty output")

endmodule

bind alert_classify_with_hysteresis_unit acwh_checker u_acwh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_data_i  (out_if.data)
);
